/* sv/tdas_pkg.sv */
// ----------------------------------------------------------------------------
// tdas_pkg
// shared types and constants for the table driven automaton step block
// ----------------------------------------------------------------------------
package tdas_pkg;

    // default sizing, used as the defaults of the top level parameters
    localparam int DEF_MAX_RULES  = 64;
    localparam int DEF_STATE_BITS = 8;

    // fixed field widths of the stream words
    localparam int SYM_W   = 8;
    localparam int FIELD_W = 8;
    localparam int MODE_W  = 2;
    localparam int OUT_W   = 16;

    // depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 2;

    // operation codes, same encoding as the mode field
    typedef enum logic [MODE_W-1:0] {
        OP_EVAL    = 2'd0,
        OP_ADD     = 2'd1,
        OP_RESTART = 2'd2,
        OP_CLEAR   = 2'd3
    } op_t;

    // one classified input word
    typedef struct packed {
        op_t                op;
        logic [SYM_W-1:0]   symbol;
        logic [FIELD_W-1:0] from_state;
        logic [FIELD_W-1:0] to_state;
    } item_t;

    // queue status towards the back end
    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_RESULT
    } bk_state_t;

endpackage

/* sv/tdas_front.sv */
// ----------------------------------------------------------------------------
// tdas_front
// accepts input words, decodes the mode and holds them in a stage register
// ----------------------------------------------------------------------------
module tdas_front
    import tdas_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // symbol, from_state, to_state
    input  logic [MODE_W-1:0]         s_tuser,   // mode
    output logic                      push,
    output item_t                     push_item,
    input  logic                      q_full
);

    logic  valid_reg, valid_next;
    item_t item_reg;
    item_t item_dec;

    // decode the word into an operation, the mode field uses the operation encoding
    always_comb begin
        item_dec.op         = op_t'(s_tuser);
        item_dec.symbol     = s_tdata[7:0];
        item_dec.from_state = s_tdata[15:8];
        item_dec.to_state   = s_tdata[23:16];
    end

    // stage register handshake
    assign push      = valid_reg && !q_full;
    assign s_tready  = !valid_reg || !q_full;
    assign push_item = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_dec;
        end
    end

endmodule

/* sv/tdas_queue.sv */
// ----------------------------------------------------------------------------
// tdas_queue
// short first-in first-out queue of decoded words between front and back
// ----------------------------------------------------------------------------
module tdas_queue
    import tdas_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  item_t   push_item,
    input  logic    pop,
    output item_t   pop_item,
    output q_stat_t stat
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign stat.valid = (cnt_reg != '0);
    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && stat.valid;
    assign pop_item   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/tdas_back.sv */
// ----------------------------------------------------------------------------
// tdas_back
// executes decoded words: rule table, rule scan, automaton state and result
// ----------------------------------------------------------------------------
module tdas_back
    import tdas_pkg::*;
#(
    parameter int MAX_RULES  = DEF_MAX_RULES,
    parameter int STATE_BITS = DEF_STATE_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  q_stat_t            q_stat,
    input  item_t              q_item,
    output logic               q_pop,
    input  logic [FIELD_W-1:0] initial_state,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata    // matched, current_state, state_valid, table_full
);

    localparam int IDX_W   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W   = $clog2(MAX_RULES + 1);
    localparam int ENTRY_W = 2 * STATE_BITS + SYM_W;
    localparam int WIDE_W  = STATE_BITS + FIELD_W;

    bk_state_t             state_reg, state_next;
    item_t                 item_reg, item_next;
    logic [STATE_BITS-1:0] cur_reg, cur_next;
    logic                  sv_reg, sv_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  pend_reg, pend_next;
    logic                  match_reg, match_next;
    logic                  full_reg, full_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic [ENTRY_W-1:0]    rule_mem [MAX_RULES];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  mem_we, mem_re;
    logic [ENTRY_W-1:0]    wr_entry;

    logic [WIDE_W-1:0]     from_wide, to_wide, init_wide, cur_wide;
    logic [STATE_BITS-1:0] ent_src, ent_dst;
    logic [SYM_W-1:0]      ent_sym;
    logic                  hit;

    // state width adaption of the byte fields
    assign from_wide = WIDE_W'(q_item.from_state);
    assign to_wide   = WIDE_W'(q_item.to_state);
    assign init_wide = WIDE_W'(initial_state);
    assign cur_wide  = WIDE_W'(cur_next);
    assign wr_entry  = {to_wide[STATE_BITS-1:0], q_item.symbol, from_wide[STATE_BITS-1:0]};

    // fields of the rule read back in the previous cycle
    assign ent_src = rd_data_reg[STATE_BITS-1:0];
    assign ent_sym = rd_data_reg[STATE_BITS+SYM_W-1:STATE_BITS];
    assign ent_dst = rd_data_reg[ENTRY_W-1:STATE_BITS+SYM_W];
    assign hit     = pend_reg && (ent_src == cur_reg) && (ent_sym == item_reg.symbol);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // sequencer: take a word, run it, hand the result to the output register
    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        cur_next       = cur_reg;
        sv_next        = sv_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        match_next     = match_reg;
        full_next      = full_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE: begin
                if (q_stat.valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    match_next = 1'b0;
                    full_next  = 1'b0;
                    idx_next   = '0;
                    state_next = BK_RESULT;
                    case (q_item.op)
                        OP_EVAL: begin
                            if (sv_reg && (count_reg != '0)) begin
                                state_next = BK_SCAN;
                            end
                        end
                        OP_ADD: begin
                            if (count_reg == CNT_W'(MAX_RULES)) begin
                                full_next = 1'b1;
                            end else begin
                                mem_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_RESTART: begin
                            cur_next = init_wide[STATE_BITS-1:0];
                            sv_next  = 1'b1;
                        end
                        default: begin
                            count_next = '0;
                        end
                    endcase
                end
            end
            BK_SCAN: begin
                // one read issued per cycle, compared in the cycle after
                if (hit) begin
                    cur_next   = ent_dst;
                    match_next = 1'b1;
                    state_next = BK_RESULT;
                end else if (idx_reg < count_reg) begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end else if (!pend_reg) begin
                    state_next = BK_RESULT;
                end
            end
            BK_RESULT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({full_reg, sv_reg, cur_wide[FIELD_W-1:0],
                                             match_reg});
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            cur_reg       <= '0;
            sv_reg        <= 1'b0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            sv_reg        <= sv_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        idx_reg      <= idx_next;
        match_reg    <= match_next;
        full_reg     <= full_next;
        out_data_reg <= out_data_next;
    end

    // rule table, appended at the fill count, read back registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rule_mem[count_reg[IDX_W-1:0]] <= wr_entry;
        end
        if (mem_re) begin
            rd_data_reg <= rule_mem[idx_reg[IDX_W-1:0]];
        end
    end

endmodule

/* sv/table_driven_automaton_step.sv */
// Path: the front stage register, the queue, the back end sequencer and its result
// register; an evaluate word also runs the rule scan.
// Flow: the back end takes a new word only after the last result is written; the
// scan reads the single-port rule table one entry a cycle through one comparator.
// Reset: synchronous on aresetn low; state, flags and rule count clear, the rule
// table needs no clearing pass.
// ----------------------------------------------------------------------------
// table_driven_automaton_step
// finite automaton with a loadable transition table, searched first match wins
// ----------------------------------------------------------------------------
module table_driven_automaton_step
    import tdas_pkg::*;
#(
    parameter int MAX_RULES  = DEF_MAX_RULES,
    parameter int STATE_BITS = DEF_STATE_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [FIELD_W-1:0] cfg_wdata,  // initial_state
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,    // symbol, from_state, to_state
    input  logic [MODE_W-1:0]  s_tuser,    // mode
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [OUT_W-1:0]   m_tdata     // matched, current_state, state_valid, table_full
);

    logic [FIELD_W-1:0] init_reg;
    logic               push;
    item_t              push_item;
    item_t              q_item;
    q_stat_t            q_stat;
    logic               q_pop;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
        end else if (cfg_we) begin
            init_reg <= cfg_wdata;
        end
    end

    tdas_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_stat.full)
    );

    tdas_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .stat      (q_stat)
    );

    tdas_back #(
        .MAX_RULES  (MAX_RULES),
        .STATE_BITS (STATE_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .initial_state (init_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata)
    );

    // a match needs a valid state
    a_match_needs_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[9]))
        else $error("match reported without a valid state");

    // a dropped rule never reports a match
    a_full_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[10]))
        else $error("table full and match in one result");

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result word present after reset");

    // once the state is valid it stays valid
    a_state_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tdata[9]) |=> (!m_tvalid || m_tdata[9]))
        else $error("state valid flag dropped");

endmodule
